>>> src/lrfp_pkg.sv
// ----------------------------------------------------------------------------
// Rangefinder frame parser package
// Shared constants and types for the frame parser and its lean compensation.
// ----------------------------------------------------------------------------
package lrfp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h59;
   localparam logic [3:0] CHECK_POS   = 4'd8;
   localparam logic [3:0] DIST_LO_POS = 4'd2;
   localparam logic [3:0] DIST_HI_POS = 4'd3;
   localparam logic [3:0] STRG_LO_POS = 4'd4;
   localparam logic [3:0] STRG_HI_POS = 4'd5;

   localparam int REG_WIDTH  = 15;
   localparam int ADDR_WIDTH = 2;

   localparam logic [ADDR_WIDTH-1:0] REG_STRENGTH_MIN = 2'd0;
   localparam logic [ADDR_WIDTH-1:0] REG_STRENGTH_MAX = 2'd1;
   localparam logic [ADDR_WIDTH-1:0] REG_DISTANCE_MIN = 2'd2;
   localparam logic [ADDR_WIDTH-1:0] REG_DISTANCE_MAX = 2'd3;

   localparam logic [REG_WIDTH-1:0] STRENGTH_MIN_RST = 15'd20;
   localparam logic [REG_WIDTH-1:0] STRENGTH_MAX_RST = 15'd3000;
   localparam logic [REG_WIDTH-1:0] DISTANCE_MIN_RST = 15'd30;
   localparam logic [REG_WIDTH-1:0] DISTANCE_MAX_RST = 15'd1200;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic signed [15:0] distance;
      logic signed [15:0] strength;
      logic [15:0]        lean_cosine;
   } frame_type;

endpackage

>>> src/lrfp_front.sv
// ----------------------------------------------------------------------------
// Rangefinder frame parser front end
// Tracks the byte position, checks headers and checksum, and queues good frames.
// ----------------------------------------------------------------------------
module lrfp_front
   import lrfp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      byte_valid,
   output logic      byte_ready,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] lean_cosine,
   output logic      push,
   output frame_type push_frame,
   input  logic      queue_full
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] dist_lo_ff, dist_hi_ff, strg_lo_ff, strg_hi_ff;
   logic [7:0] sum_base;
   logic       at_check;
   logic       accept;

   assign at_check   = (pos_ff >= CHECK_POS);
   assign byte_ready = !at_check || !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign sum_base   = (pos_ff == 4'd0) ? 8'd0 : sum_ff;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         priority if (pos_ff < DIST_LO_POS) begin
            if (rx_byte == HEADER_BYTE) begin
               pos_in = pos_ff + 4'd1;
               sum_in = sum_base + rx_byte;
            end else begin
               pos_in = 4'd0;
               sum_in = sum_base;
            end
         end else if (!at_check) begin
            pos_in = pos_ff + 4'd1;
            sum_in = sum_base + rx_byte;
         end else begin
            pos_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
         sum_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (pos_ff == DIST_LO_POS) dist_lo_ff <= rx_byte;
         if (pos_ff == DIST_HI_POS) dist_hi_ff <= rx_byte;
         if (pos_ff == STRG_LO_POS) strg_lo_ff <= rx_byte;
         if (pos_ff == STRG_HI_POS) strg_hi_ff <= rx_byte;
      end
   end

   assign push                   = accept && at_check && (sum_ff == rx_byte);
   assign push_frame.distance    = {dist_hi_ff, dist_lo_ff};
   assign push_frame.strength    = {strg_hi_ff, strg_lo_ff};
   assign push_frame.lean_cosine = lean_cosine;

endmodule

>>> src/lrfp_queue.sv
// ----------------------------------------------------------------------------
// Rangefinder frame queue
// Small first-in first-out store of good frames between front and back end.
// ----------------------------------------------------------------------------
module lrfp_queue
   import lrfp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_frame,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output frame_type pop_frame
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   frame_type              store_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_frame = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

>>> src/lrfp_back.sv
// ----------------------------------------------------------------------------
// Rangefinder frame parser back end
// Holds the limit registers, tests each frame and forms the lean-compensated
// height in a multiply stage followed by the result register.
// ----------------------------------------------------------------------------
module lrfp_back
   import lrfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [ADDR_WIDTH-1:0] csr_addr,
   input  logic [REG_WIDTH-1:0]  csr_wdata,
   input  logic                  frame_valid,
   input  frame_type             frame,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic                  rsp_tuser
);

   logic [REG_WIDTH-1:0] strength_min_ff, strength_max_ff;
   logic [REG_WIDTH-1:0] distance_min_ff, distance_max_ff;

   logic               s1_valid_ff;
   logic               s1_ok_ff, s1_ok_in;
   logic [31:0]        s1_product_ff;
   logic signed [15:0] s1_dist_ff, s1_strg_ff;

   logic               out_valid_ff;
   logic               out_ok_ff;
   logic [15:0]        out_height_ff, out_height_in;
   logic [15:0]        out_dist_ff, out_strg_ff;

   logic               out_ready, s1_adv;
   logic [16:0]        height_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_min_ff <= STRENGTH_MIN_RST;
         strength_max_ff <= STRENGTH_MAX_RST;
         distance_min_ff <= DISTANCE_MIN_RST;
         distance_max_ff <= DISTANCE_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_STRENGTH_MIN: strength_min_ff <= csr_wdata;
            REG_STRENGTH_MAX: strength_max_ff <= csr_wdata;
            REG_DISTANCE_MIN: distance_min_ff <= csr_wdata;
            REG_DISTANCE_MAX: distance_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s1_adv    = s1_valid_ff && out_ready;
   assign pop       = frame_valid && (!s1_valid_ff || out_ready);

   assign s1_ok_in = (frame.strength > $signed({1'b0, strength_min_ff})) &&
                     (frame.strength < $signed({1'b0, strength_max_ff})) &&
                     (frame.distance > $signed({1'b0, distance_min_ff})) &&
                     (frame.distance < $signed({1'b0, distance_max_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ok_ff      <= s1_ok_in;
         s1_product_ff <= $unsigned(frame.distance) * frame.lean_cosine;
         s1_dist_ff    <= frame.distance;
         s1_strg_ff    <= frame.strength;
      end
   end

   assign height_wide = s1_product_ff[31:15];

   always_comb begin
      if (!s1_ok_ff) begin
         out_height_in = 16'd0;
      end else if (height_wide[16] || height_wide[15]) begin
         out_height_in = 16'h7FFF;
      end else begin
         out_height_in = height_wide[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ok_ff     <= s1_ok_ff;
         out_height_ff <= out_height_in;
         out_dist_ff   <= s1_dist_ff;
         out_strg_ff   <= s1_strg_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {out_strg_ff, out_dist_ff, out_height_ff};

endmodule

>>> src/lidar_range_frame_parser.sv
// ----------------------------------------------------------------------------
// Rangefinder frame parser
// Parses nine-byte rangefinder frames and reports lean-compensated heights.
//
//   Channel  Dir  Contents
//   req_     in   tdata: rx_byte [7:0], lean_cosine [23:8]
//   rsp_     out  tdata: height_cm, raw_distance, signal_strength; tuser: available
//   csr_     in   write enable, register index, 15-bit data
//
// One byte is taken every cycle while the frame queue has room; only the
// checksum byte needs a free queue entry.
// A good frame's result passes, after its checksum byte, through a queue stage,
// a multiply stage and the result register.
// Reset is synchronous; it clears positions, queue and result valid, and loads
// the limit registers with their defaults.
// A stalled result side fills the queue and then holds back checksum bytes.
// ----------------------------------------------------------------------------
module lidar_range_frame_parser
   import lrfp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // rx_byte, lean_cosine
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // height_cm, raw_distance, signal_strength
   output logic                  rsp_tuser,   // available
   input  logic                  csr_we,
   input  logic [ADDR_WIDTH-1:0] csr_addr,
   input  logic [REG_WIDTH-1:0]  csr_wdata
);

   logic      push, pop, queue_full, queue_not_empty;
   frame_type push_frame, pop_frame;

   lrfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .rx_byte     (req_tdata[7:0]),
      .lean_cosine (req_tdata[23:8]),
      .push        (push),
      .push_frame  (push_frame),
      .queue_full  (queue_full)
   );

   lrfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .pop_frame  (pop_frame)
   );

   lrfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .frame_valid (queue_not_empty),
      .frame       (pop_frame),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

>>> src/lrfp_checker.sv
// ----------------------------------------------------------------------------
// Rangefinder frame parser checker
// Port-level properties of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module lrfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // An unavailable result never carries a height.
   a_unavail_zero_height: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("unavailable item carries a height");

   // A passing frame has non-negative distance, strength and height.
   a_avail_signs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[15] && !rsp_tdata[31] && !rsp_tdata[47])
      else $error("available item with a negative field");

   // No result can leave straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid just after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind lidar_range_frame_parser lrfp_checker u_lrfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
